/* hdl/bech_pkg.sv */
// Shared types, constants and functions of the uppercase bech32 encoder.
// Used by the front, queue, back and top level in hdl/; depends on nothing else.
package bech_pkg;

    // Length limits of one encoded string
    localparam int MAX_OUT    = 90;
    localparam int PREFIX_MAX = 83;
    localparam int PFX_AW     = $clog2(PREFIX_MAX);
    localparam int LEN_W      = 7;

    // Command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    // Item opcodes
    localparam logic [1:0] OP_PREFIX = 2'd0;
    localparam logic [1:0] OP_DATA   = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // Character codes
    localparam logic [7:0] CHAR_MIN = 8'd33;
    localparam logic [7:0] CHAR_MAX = 8'd126;
    localparam logic [7:0] UPPER_A  = 8'h41;
    localparam logic [7:0] UPPER_Z  = 8'h5a;
    localparam logic [7:0] LOWER_A  = 8'h61;
    localparam logic [7:0] LOWER_Z  = 8'h7a;
    localparam logic [7:0] CASE_GAP = 8'd32;
    localparam logic [7:0] SEP_CHAR = 8'h31;
    localparam logic [7:0] ERR_CHAR = 8'h00;

    // Symbol alphabet, first symbol in the top byte
    localparam logic [8*32-1:0] CHARSET = "QPZRY9X8GF2TVDW0S3JN54KHCE6MUA7L";

    // BCH generator terms
    localparam logic [29:0] GEN0 = 30'h3b6a57b2;
    localparam logic [29:0] GEN1 = 30'h26508e6d;
    localparam logic [29:0] GEN2 = 30'h1ea119fa;
    localparam logic [29:0] GEN3 = 30'h3d4233dd;
    localparam logic [29:0] GEN4 = 30'h2a1462b3;

    // Classified item as it travels through the queue
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] value;    // data byte, or prefix character in upper case
        logic       char_ok;  // prefix character inside the printable range
        logic [2:0] hi;       // high bits of the lower-case character
        logic [4:0] lo;       // low bits of the lower-case character
    } t_cmd;

    // Queue status
    typedef struct packed {
        logic           empty;
        logic           full;
        logic [QAW:0]   count;
    } t_q_stat;

    // One step of the checksum polynomial
    function automatic logic [29:0] fold(input logic [29:0] acc, input logic [4:0] sym);
        logic [29:0] r;
        logic [4:0]  top;
        top = acc[29:25];
        r   = {acc[24:0], sym};
        if (top[0]) r = r ^ GEN0;
        if (top[1]) r = r ^ GEN1;
        if (top[2]) r = r ^ GEN2;
        if (top[3]) r = r ^ GEN3;
        if (top[4]) r = r ^ GEN4;
        return r;
    endfunction

    // Symbol to uppercase character
    function automatic logic [7:0] sym_char(input logic [4:0] sym);
        logic [4:0] pos;
        pos = 5'd31 - sym;
        return CHARSET[{pos, 3'b000} +: 8];
    endfunction

endpackage

/* hdl/bech32_upper_encoder.sv */
// Top level of the streaming uppercase bech32 encoder.
// Depends on bech_pkg, bech_front, bech_fifo, bech_back (and bech_ram below it).
//
//  channel | dir | handshake                  | fields
//  --------+-----+----------------------------+-------------------------------
//  input   | in  | i_in_valid  / o_in_stall   | i_op, i_value
//  output  | out | o_out_valid / i_out_stall  | o_character, o_last, o_error
//
// Front: one item per cycle while the two-entry command queue has room.
// Back: prefix characters, dropped items and errors are handled in the idle state; a data
// byte emits one or two 5-bit symbols; finish emits any tail symbol and six checksum characters.
// The first data or finish item first replays the prefix RAM and emits the separator.
// Reset is synchronous, active low; no clearing pass is needed. A stalled output
// holds its register and the back; the input stalls once the queue is full.
module bech32_upper_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_op,
    input  logic [7:0] i_value,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_character,
    output logic       o_last,
    output logic       o_error
);

    bech_pkg::t_cmd    w_front_cmd;
    bech_pkg::t_cmd    w_q_cmd;
    bech_pkg::t_q_stat w_q_stat;
    logic              w_push;
    logic              w_pop;

    bech_front u_front (
        .i_valid  (i_in_valid),
        .o_stall  (o_in_stall),
        .i_op     (i_op),
        .i_value  (i_value),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_cmd    (w_front_cmd)
    );

    bech_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_q_cmd),
        .o_stat  (w_q_stat)
    );

    bech_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_q_cmd),
        .i_q_stat    (w_q_stat),
        .o_pop       (w_pop),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_character (o_character),
        .o_last      (o_last),
        .o_error     (o_error)
    );

`ifndef SYNTH
    // An error result closes the message and carries no character
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error) |-> (o_last && o_character == bech_pkg::ERR_CHAR))
        else $error("error result not marked last or carries a character");

    // The back never takes a command from an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("pop from empty command queue");

    // The queue fill never exceeds its depth
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_stat.count <= (bech_pkg::QAW + 1)'(bech_pkg::QDEPTH))
        else $error("command queue overflow");

    // A full queue stalls the input and takes no push
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_stat.full |-> (!w_push && o_in_stall))
        else $error("push into full command queue");
`endif

endmodule

/* hdl/bech_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bech_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/bech_front.sv */
// Input side: accepts items and classifies them into queue commands.
// Depends on bech_pkg.
module bech_front (
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [1:0]       i_op,
    input  logic [7:0]       i_value,
    input  bech_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output bech_pkg::t_cmd   o_cmd
);

    logic       w_is_upper;
    logic       w_is_lower;
    logic [7:0] w_lower;
    logic [7:0] w_upper;

    // Hold the input while the queue is full; drop unused opcodes
    assign o_stall = i_q_stat.full;
    assign o_push  = i_valid && !i_q_stat.full && (i_op != bech_pkg::OP_NONE);

    // Case folding of prefix characters
    always_comb begin
        w_is_upper = (i_value >= bech_pkg::UPPER_A) && (i_value <= bech_pkg::UPPER_Z);
        w_is_lower = (i_value >= bech_pkg::LOWER_A) && (i_value <= bech_pkg::LOWER_Z);
        w_lower    = w_is_upper ? i_value + bech_pkg::CASE_GAP : i_value;
        w_upper    = w_is_lower ? i_value - bech_pkg::CASE_GAP : i_value;
    end

    // Build the command
    always_comb begin
        o_cmd.op      = i_op;
        o_cmd.value   = (i_op == bech_pkg::OP_PREFIX) ? w_upper : i_value;
        o_cmd.char_ok = (i_value >= bech_pkg::CHAR_MIN) && (i_value <= bech_pkg::CHAR_MAX);
        o_cmd.hi      = w_lower[7:5];
        o_cmd.lo      = w_lower[4:0];
    end

endmodule

/* hdl/bech_fifo.sv */
// Short command queue between the classifying front and the encoding back.
// Depends on bech_pkg.
module bech_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bech_pkg::t_cmd    i_cmd,
    input  logic              i_pop,
    output bech_pkg::t_cmd    o_cmd,
    output bech_pkg::t_q_stat o_stat
);

    localparam logic [bech_pkg::QAW-1:0] LAST_PTR = bech_pkg::QAW'(bech_pkg::QDEPTH - 1);
    localparam logic [bech_pkg::QAW:0]   FULL_CNT = (bech_pkg::QAW + 1)'(bech_pkg::QDEPTH);

    bech_pkg::t_cmd             r_mem [bech_pkg::QDEPTH];
    logic [bech_pkg::QAW-1:0]   r_wptr;
    logic [bech_pkg::QAW-1:0]   r_rptr;
    logic [bech_pkg::QAW:0]     r_count;
    logic [bech_pkg::QAW-1:0]   n_wptr;
    logic [bech_pkg::QAW-1:0]   n_rptr;
    logic [bech_pkg::QAW:0]     n_count;

    // Advance pointers with wrap
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Store the payload
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    assign o_cmd        = r_mem[r_rptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == FULL_CNT);
    assign o_stat.count = r_count;

endmodule

/* hdl/bech_back.sv */
// Encoding back end: checksum, prefix store, symbol regrouping, output register.
// Depends on bech_pkg and bech_ram.
module bech_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bech_pkg::t_cmd    i_cmd,
    input  bech_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_character,
    output logic              o_last,
    output logic              o_error
);

    // Sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ZERO   = 4'd1;
    localparam logic [3:0] S_REPLAY = 4'd2;
    localparam logic [3:0] S_SEP    = 4'd3;
    localparam logic [3:0] S_DSYM   = 4'd4;
    localparam logic [3:0] S_TAIL   = 4'd5;
    localparam logic [3:0] S_PAD    = 4'd6;
    localparam logic [3:0] S_CSUM   = 4'd7;

    // Message phases
    localparam logic [1:0] PH_PREFIX = 2'd0;
    localparam logic [1:0] PH_DATA   = 2'd1;
    localparam logic [1:0] PH_DROP   = 2'd2;

    localparam int         LW        = bech_pkg::LEN_W;
    localparam int         AW        = bech_pkg::PFX_AW;
    localparam logic [2:0] STEP_LAST = 3'd5;   // six checksum steps, counted from zero
    localparam logic [7:0] MAX_LEN   = 8'(bech_pkg::MAX_OUT);
    localparam logic [7:0] CSUM_LEN  = 8'd6;
    localparam logic [7:0] PFX_TAIL  = 8'd8;   // separator plus checksum plus one
    localparam logic [7:0] SYM_TWO   = 8'd2;
    localparam logic [7:0] SYM_THREE = 8'd3;
    localparam logic [3:0] SYM_BITS  = 4'd5;
    localparam logic [3:0] BYTE_BITS = 4'd8;

    logic [3:0]    r_state, n_state;
    logic [1:0]    r_phase, n_phase;
    logic [29:0]   r_ck, n_ck;
    logic [3:0]    r_lv, n_lv;
    logic [2:0]    r_lc, n_lc;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_emit, n_emit;
    logic [LW-1:0] r_idx, n_idx;
    logic [2:0]    r_cnt, n_cnt;
    logic [11:0]   r_acc, n_acc;
    logic [3:0]    r_bits, n_bits;
    logic [1:0]    r_kind, n_kind;

    logic          r_o_valid;
    logic [7:0]    r_o_char;
    logic          r_o_last;
    logic          r_o_err;

    logic          w_emit_ok;
    logic          w_ld;
    logic [7:0]    w_ld_char;
    logic          w_ld_last;
    logic          w_fail;
    logic          w_clr_msg;
    logic          w_ram_we;
    logic [AW-1:0] w_rd_addr;
    logic [4:0]    w_rd_data;
    logic          w_pfx_full;
    logic [7:0]    w_base;
    logic [7:0]    w_total;
    logic          w_too_long;
    logic [3:0]    w_nb;
    logic [4:0]    w_dsym;
    logic [3:0]    w_keep;
    logic [4:0]    w_tsym;
    logic [LW-1:0] w_idx_inc;

    // Stored low parts of the prefix
    bech_ram #(
        .WIDTH (5),
        .DEPTH (bech_pkg::PREFIX_MAX)
    ) u_pfx_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_we),
        .i_wr_addr (r_len[AW-1:0]),
        .i_wr_data (i_cmd.lo),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Length checks and symbol extraction
    always_comb begin
        w_emit_ok  = !r_o_valid || !i_stall;
        w_pfx_full = (r_len >= LW'(bech_pkg::PREFIX_MAX))
                     || (({1'b0, r_len} + PFX_TAIL) > MAX_LEN);
        w_base     = (r_phase == PH_PREFIX) ? {1'b0, r_len} + 8'd1 : {1'b0, r_emit};
        w_total    = w_base + ((r_lc >= 3'd3) ? SYM_THREE : SYM_TWO) + CSUM_LEN;
        w_too_long = w_total > MAX_LEN;
        w_nb       = r_bits - SYM_BITS;
        w_dsym     = 5'(r_acc >> w_nb);
        for (int j = 0; j < 4; j++) begin
            w_keep[j] = r_acc[j] && (4'(j) < w_nb);
        end
        w_tsym     = 5'({1'b0, r_lv} << (3'd5 - r_lc));
        w_idx_inc  = r_idx + 1'b1;
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_ck      = r_ck;
        n_lv      = r_lv;
        n_lc      = r_lc;
        n_len     = r_len;
        n_emit    = r_emit;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_acc     = r_acc;
        n_bits    = r_bits;
        n_kind    = r_kind;
        w_ld      = 1'b0;
        w_ld_char = bech_pkg::ERR_CHAR;
        w_ld_last = 1'b0;
        w_fail    = 1'b0;
        w_clr_msg = 1'b0;
        w_ram_we  = 1'b0;
        w_rd_addr = '0;
        o_pop     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty && w_emit_ok) begin
                    o_pop  = 1'b1;
                    n_kind = i_cmd.op;
                    n_cnt  = '0;
                    if (r_phase == PH_DROP) begin
                        // drop the rest of a rejected message
                        w_clr_msg = (i_cmd.op == bech_pkg::OP_FINISH);
                    end else if (i_cmd.op == bech_pkg::OP_PREFIX) begin
                        if (r_phase != PH_PREFIX || !i_cmd.char_ok || w_pfx_full) begin
                            w_fail = 1'b1;
                        end else begin
                            n_ck      = bech_pkg::fold(r_ck, {2'b00, i_cmd.hi});
                            w_ram_we  = 1'b1;
                            n_len     = r_len + 1'b1;
                            n_emit    = r_len + 1'b1;
                            w_ld      = 1'b1;
                            w_ld_char = i_cmd.value;
                        end
                    end else if (r_phase == PH_PREFIX && r_len == '0) begin
                        // empty prefix
                        w_fail    = 1'b1;
                        w_clr_msg = (i_cmd.op == bech_pkg::OP_FINISH);
                    end else if (i_cmd.op == bech_pkg::OP_DATA) begin
                        if (w_too_long) begin
                            w_fail = 1'b1;
                        end else begin
                            n_acc   = {r_lv, i_cmd.value};
                            n_bits  = {1'b0, r_lc} + BYTE_BITS;
                            n_state = (r_phase == PH_PREFIX) ? S_ZERO : S_DSYM;
                        end
                    end else begin
                        if (r_phase == PH_PREFIX) begin
                            n_state = S_ZERO;
                        end else begin
                            n_state = (r_lc != '0) ? S_TAIL : S_PAD;
                        end
                    end
                end
            end
            S_ZERO: begin
                // separator step; read address zero is presented now
                n_ck    = bech_pkg::fold(r_ck, 5'd0);
                n_idx   = '0;
                n_state = S_REPLAY;
            end
            S_REPLAY: begin
                n_ck = bech_pkg::fold(r_ck, w_rd_data);
                if (w_idx_inc == r_len) begin
                    n_state = S_SEP;
                end else begin
                    n_idx     = w_idx_inc;
                    w_rd_addr = w_idx_inc[AW-1:0];
                end
            end
            S_SEP: begin
                if (w_emit_ok) begin
                    w_ld      = 1'b1;
                    w_ld_char = bech_pkg::SEP_CHAR;
                    n_emit    = r_len + 1'b1;
                    n_phase   = PH_DATA;
                    if (r_kind == bech_pkg::OP_DATA) begin
                        n_state = S_DSYM;
                    end else begin
                        n_state = (r_lc != '0) ? S_TAIL : S_PAD;
                    end
                end
            end
            S_DSYM: begin
                if (w_emit_ok) begin
                    n_ck      = bech_pkg::fold(r_ck, w_dsym);
                    w_ld      = 1'b1;
                    w_ld_char = bech_pkg::sym_char(w_dsym);
                    n_emit    = r_emit + 1'b1;
                    n_bits    = w_nb;
                    if (w_nb < SYM_BITS) begin
                        n_lc    = w_nb[2:0];
                        n_lv    = w_keep;
                        n_state = S_IDLE;
                    end
                end
            end
            S_TAIL: begin
                if (w_emit_ok) begin
                    n_ck      = bech_pkg::fold(r_ck, w_tsym);
                    w_ld      = 1'b1;
                    w_ld_char = bech_pkg::sym_char(w_tsym);
                    n_cnt     = '0;
                    n_state   = S_PAD;
                end
            end
            S_PAD: begin
                n_ck = bech_pkg::fold(r_ck, 5'd0);
                if (r_cnt == STEP_LAST) begin
                    n_ck    = bech_pkg::fold(r_ck, 5'd0) ^ 30'd1;
                    n_cnt   = '0;
                    n_state = S_CSUM;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_CSUM: begin
                if (w_emit_ok) begin
                    w_ld      = 1'b1;
                    w_ld_char = bech_pkg::sym_char(r_ck[29:25]);
                    w_ld_last = (r_cnt == STEP_LAST);
                    n_ck      = {r_ck[24:0], 5'd0};
                    n_cnt     = r_cnt + 1'b1;
                    if (r_cnt == STEP_LAST) begin
                        w_clr_msg = 1'b1;
                        n_state   = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // reject the message
        if (w_fail) begin
            w_ld      = 1'b1;
            w_ld_char = bech_pkg::ERR_CHAR;
            w_ld_last = 1'b1;
            n_phase   = PH_DROP;
        end

        // start a new message
        if (w_clr_msg) begin
            n_ck    = 30'd1;
            n_lv    = '0;
            n_lc    = '0;
            n_len   = '0;
            n_emit  = '0;
            n_phase = PH_PREFIX;
        end
    end

    // Control and message state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_PREFIX;
            r_ck    <= 30'd1;
            r_lv    <= '0;
            r_lc    <= '0;
            r_len   <= '0;
            r_emit  <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_ck    <= n_ck;
            r_lv    <= n_lv;
            r_lc    <= n_lc;
            r_len   <= n_len;
            r_emit  <= n_emit;
        end
    end

    // Working registers of the current item
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_cnt  <= n_cnt;
        r_acc  <= n_acc;
        r_bits <= n_bits;
        r_kind <= n_kind;
    end

    // Output register: load on emit, drop valid once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_ld) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld) begin
            r_o_char <= w_ld_char;
            r_o_last <= w_ld_last;
            r_o_err  <= w_fail;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_character = r_o_char;
    assign o_last      = r_o_last;
    assign o_error     = r_o_err;

endmodule

/* tb/tb_bech32_upper_encoder.sv */
// Self-checking testbench of the streaming uppercase bech32 encoder.
// Depends on bech_pkg and bech32_upper_encoder; predicts every output character
// from its own encoder state and checks each output transfer against it.
module tb_bech32_upper_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MSG_MAX     = 90;
    localparam int PFX_MAX     = 83;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 150;
    localparam int DRAIN_WAIT  = 120;

    localparam logic [7:0] CH_SEP = 8'h31;
    localparam logic [7:0] CH_ERR = 8'h00;
    localparam logic [7:0] CH_LO  = 8'd33;
    localparam logic [7:0] CH_HI  = 8'd126;

    localparam logic [8*32-1:0] ALPHABET = "QPZRY9X8GF2TVDW0S3JN54KHCE6MUA7L";
    localparam logic [4:0][29:0] BCH_GEN = {
        30'h2a1462b3, 30'h3d4233dd, 30'h1ea119fa, 30'h26508e6d, 30'h3b6a57b2
    };

    typedef enum logic [1:0] {MSG_PREFIX, MSG_DATA, MSG_DROP} t_msg_phase;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       err;
    } t_enc_char;

    // Clock, reset and channel signals
    logic       i_clk;
    logic       i_rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] in_op;
    logic [7:0] in_value;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_char;
    logic       out_last;
    logic       out_error;

    // Expected characters and encoder state of the predictor
    t_enc_char   pending_chars[$];
    logic [29:0] enc_sum;
    logic [3:0]  tail_bits;
    int          tail_count;
    logic [4:0]  low_parts[PFX_MAX];
    int          prefix_len;
    int          out_len;
    t_msg_phase  msg_phase;

    // Run control
    int fail_count    = 0;
    int items_sent    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int holds_seen    = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    bech32_upper_encoder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_op        (in_op),
        .i_value     (in_value),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_character (out_char),
        .o_last      (out_last),
        .o_error     (out_error)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // One step of the 30-bit BCH checksum
    function automatic logic [29:0] bch_step(input logic [29:0] acc, input logic [4:0] sym);
        logic [29:0] r;
        r = {acc[24:0], sym};
        for (int k = 0; k < 5; k++)
            if (acc[25 + k]) r = r ^ BCH_GEN[k];
        return r;
    endfunction

    function automatic logic [7:0] sym_to_char(input logic [4:0] sym);
        int pos;
        pos = 31 - int'(sym);
        return ALPHABET[8 * pos +: 8];
    endfunction

    function automatic void emit_char(input logic [7:0] ch, input logic last, input logic err);
        t_enc_char c;
        c.ch   = ch;
        c.last = last;
        c.err  = err;
        pending_chars.push_back(c);
    endfunction

    function automatic void start_message();
        enc_sum    = 30'd1;
        tail_bits  = 4'd0;
        tail_count = 0;
        prefix_len = 0;
        out_len    = 0;
        msg_phase  = MSG_PREFIX;
    endfunction

    function automatic void reject_message();
        msg_phase = MSG_DROP;
        emit_char(CH_ERR, 1'b1, 1'b1);
    endfunction

    // Fold the separator and the stored low parts, then emit the separator
    function automatic void close_prefix();
        enc_sum = bch_step(enc_sum, 5'd0);
        for (int i = 0; i < prefix_len; i++)
            enc_sum = bch_step(enc_sum, low_parts[i]);
        out_len   = prefix_len + 1;
        msg_phase = MSG_DATA;
        emit_char(CH_SEP, 1'b0, 1'b0);
    endfunction

    // Advance the predicted encoder by one accepted item
    function automatic void encode_item(input logic [1:0] op, input logic [7:0] v);
        logic [7:0]  low;
        logic [11:0] acc;
        logic [4:0]  sym;
        int          base;
        int          nbits;
        int          total;
        if (op == bech_pkg::OP_NONE) return;
        if (msg_phase == MSG_DROP) begin
            if (op == bech_pkg::OP_FINISH) start_message();
            return;
        end
        if (op == bech_pkg::OP_PREFIX) begin
            if (msg_phase != MSG_PREFIX || v < CH_LO || v > CH_HI || prefix_len >= PFX_MAX
                    || prefix_len + 8 > MSG_MAX) begin
                reject_message();
                return;
            end
            low = (v >= "A" && v <= "Z") ? v + 8'd32 : v;
            enc_sum = bch_step(enc_sum, {2'b00, low[7:5]});
            low_parts[prefix_len] = low[4:0];
            prefix_len++;
            out_len = prefix_len;
            emit_char((v >= "a" && v <= "z") ? v - 8'd32 : v, 1'b0, 1'b0);
            return;
        end
        if (msg_phase == MSG_PREFIX && prefix_len == 0) begin
            reject_message();
            if (op == bech_pkg::OP_FINISH) start_message();
            return;
        end
        if (op == bech_pkg::OP_DATA) begin
            base  = (msg_phase == MSG_PREFIX) ? prefix_len + 1 : out_len;
            nbits = tail_count + 8;
            acc   = {tail_bits, v};
            total = base + nbits / 5 + ((nbits % 5 != 0) ? 1 : 0) + 6;
            if (total > MSG_MAX) begin
                reject_message();
                return;
            end
            if (msg_phase == MSG_PREFIX) close_prefix();
            while (nbits >= 5) begin
                nbits -= 5;
                sym = 5'(acc >> nbits);
                enc_sum = bch_step(enc_sum, sym);
                emit_char(sym_to_char(sym), 1'b0, 1'b0);
                out_len++;
            end
            tail_count = nbits;
            tail_bits  = 4'(acc & ((12'd1 << nbits) - 12'd1));
            return;
        end
        // Finish: pad the tail group, then the six checksum characters
        if (msg_phase == MSG_PREFIX) close_prefix();
        if (tail_count > 0) begin
            sym = 5'({1'b0, tail_bits} << (5 - tail_count));
            enc_sum = bch_step(enc_sum, sym);
            emit_char(sym_to_char(sym), 1'b0, 1'b0);
        end
        for (int k = 0; k < 6; k++)
            enc_sum = bch_step(enc_sum, 5'd0);
        enc_sum = enc_sum ^ 30'd1;
        for (int k = 0; k < 6; k++)
            emit_char(sym_to_char(5'(enc_sum >> (5 * (5 - k)))), k == 5, 1'b0);
        start_message();
    endfunction

    // Offer one item, idling first at random, and hold it until the transfer
    task automatic send_item(input logic [1:0] op, input logic [7:0] value);
        @(negedge i_clk);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_op    <= op;
        in_value <= value;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        encode_item(op, value);
        items_sent++;
    endtask

    task automatic send_prefix_run(input int len);
        for (int i = 0; i < len; i++)
            send_item(bech_pkg::OP_PREFIX, 8'($urandom_range(126, 33)));
    endtask

    // Receiver: random stalls, or a long hold when one is requested
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_requests != holds_seen) begin
            holds_seen = hold_requests;
            hold_left  = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Compare each output transfer with the oldest expected character
    always @(posedge i_clk) begin
        t_enc_char want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected character: actual ch=%02h last=%0b err=%0b",
                         $time, out_char, out_last, out_error);
                fail_count++;
            end else begin
                want = pending_chars.pop_front();
                if (out_char !== want.ch || out_last !== want.last || out_error !== want.err) begin
                    $display("%0t: mismatch: expected ch=%02h last=%0b err=%0b, actual ch=%02h last=%0b err=%0b",
                             $time, want.ch, want.last, want.err, out_char, out_last, out_error);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles = 0;
        end else if (i_rst_n) begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: timeout, %0d characters still expected", $time, pending_chars.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Well-formed messages with mixed case, range edges and byte extremes
    task automatic test_basic_messages();
        send_item(bech_pkg::OP_PREFIX, "A");
        send_item(bech_pkg::OP_PREFIX, "z");
        send_item(bech_pkg::OP_PREFIX, CH_LO);
        send_item(bech_pkg::OP_PREFIX, CH_HI);
        send_item(bech_pkg::OP_DATA, 8'h00);
        send_item(bech_pkg::OP_DATA, 8'hff);
        send_item(bech_pkg::OP_DATA, 8'ha5);
        send_item(bech_pkg::OP_FINISH, 8'h00);
        // prefix then finish with no data
        send_item(bech_pkg::OP_PREFIX, "x");
        send_item(bech_pkg::OP_FINISH, 8'hff);
        // tail group of one bit left at finish
        send_item(bech_pkg::OP_PREFIX, "b");
        send_item(bech_pkg::OP_DATA, 8'h5a);
        send_item(bech_pkg::OP_DATA, 8'h3c);
        send_item(bech_pkg::OP_FINISH, 8'h00);
    endtask

    // Bad characters, empty prefix, late prefix, unused op and dropping phase
    task automatic test_rejections();
        send_item(bech_pkg::OP_PREFIX, 8'd32);
        send_item(bech_pkg::OP_DATA, 8'h12);
        send_item(bech_pkg::OP_PREFIX, "q");
        send_item(bech_pkg::OP_FINISH, 8'h00);
        send_item(bech_pkg::OP_PREFIX, "c");
        send_item(bech_pkg::OP_PREFIX, 8'd127);
        send_item(bech_pkg::OP_FINISH, 8'h00);
        send_item(bech_pkg::OP_PREFIX, 8'h00);
        send_item(bech_pkg::OP_FINISH, 8'h00);
        send_item(bech_pkg::OP_PREFIX, 8'hff);
        send_item(bech_pkg::OP_FINISH, 8'h00);
        // empty prefix: data drops the rest, finish restarts at once
        send_item(bech_pkg::OP_DATA, 8'h77);
        send_item(bech_pkg::OP_FINISH, 8'h00);
        send_item(bech_pkg::OP_FINISH, 8'h00);
        // late prefix, with an unused op in the middle
        send_item(bech_pkg::OP_PREFIX, "m");
        send_item(bech_pkg::OP_NONE, 8'h81);
        send_item(bech_pkg::OP_DATA, 8'h40);
        send_item(bech_pkg::OP_PREFIX, "n");
        send_item(bech_pkg::OP_DATA, 8'h01);
        send_item(bech_pkg::OP_FINISH, 8'h00);
    endtask

    // Longest prefix plus one, and data past the maximum length after a long prefix
    task automatic test_length_limits();
        send_prefix_run(PFX_MAX);
        send_item(bech_pkg::OP_PREFIX, "k");
        send_item(bech_pkg::OP_FINISH, 8'h00);
        // first byte fills the string to the limit, the second overflows it
        send_prefix_run(PFX_MAX - 2);
        send_item(bech_pkg::OP_DATA, 8'($urandom_range(255)));
        send_item(bech_pkg::OP_DATA, 8'($urandom_range(255)));
        send_item(bech_pkg::OP_FINISH, 8'h00);
    endtask

    // Random messages, mostly well formed, the rest noise and broken sequences
    task automatic test_random_traffic(input int item_budget);
        int stop_at;
        int plen;
        int room;
        int ndata;
        int nnoise;
        stop_at = items_sent + item_budget;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 75) begin
                plen = ($urandom_range(9) == 0) ? $urandom_range(PFX_MAX, 20) : $urandom_range(8, 1);
                room = ((MSG_MAX - plen - 7) * 5) / 8;
                if ($urandom_range(7) == 0)
                    ndata = room + $urandom_range(2);
                else
                    ndata = $urandom_range((room < 12) ? room : 12);
                send_prefix_run(plen);
                for (int i = 0; i < ndata; i++)
                    send_item(bech_pkg::OP_DATA, 8'($urandom_range(255)));
                send_item(bech_pkg::OP_FINISH, 8'($urandom_range(255)));
            end else begin
                nnoise = $urandom_range(6, 1);
                for (int i = 0; i < nnoise; i++)
                    send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
                if ($urandom_range(1) == 1)
                    send_item(bech_pkg::OP_FINISH, 8'($urandom_range(255)));
            end
        end
    endtask

    // Hold the output for a long stretch while a full message keeps coming
    task automatic test_output_hold();
        hold_requests++;
        send_prefix_run(6);
        for (int i = 0; i < 8; i++)
            send_item(bech_pkg::OP_DATA, 8'($urandom_range(255)));
        send_item(bech_pkg::OP_FINISH, 8'h00);
    endtask

    initial begin
        i_rst_n  = 1'b0;
        in_valid = 1'b0;
        in_op    = bech_pkg::OP_NONE;
        in_value = 8'h00;
        start_message();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_pct = 17;
        recv_idle_pct = 76;
        test_basic_messages();
        test_rejections();
        test_length_limits();
        test_random_traffic(12);

        send_idle_pct = 76;
        recv_idle_pct = 17;
        test_random_traffic(12);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_output_hold();
        test_random_traffic(10);

        // Drain, then allow trailing dropped items to settle
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_chars.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (pending_chars.size() > 0) begin
            $display("%0t: %0d characters never arrived", $time, pending_chars.size());
            fail_count++;
        end

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* sim.f */
hdl/bech_pkg.sv
hdl/bech_ram.sv
hdl/bech_front.sv
hdl/bech_fifo.sv
hdl/bech_back.sv
hdl/bech32_upper_encoder.sv
tb/tb_bech32_upper_encoder.sv
